[design/set_assoc_cache_lru_tracker_defines.svh]
// Assertion macros used by the cache tracker RTL.
`ifndef SET_ASSOC_CACHE_LRU_TRACKER_DEFINES_SVH
`define SET_ASSOC_CACHE_LRU_TRACKER_DEFINES_SVH

// Implication checked in the same cycle.
`define SACL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the next cycle.
`define SACL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/sacl_pkg.sv]
package sacl_pkg;

  localparam int DEF_MAX_SETS = 64;
  localparam int DEF_MAX_WAYS = 8;

  localparam int ADDR_W = 64;
  localparam int TAG_W  = 62;
  localparam int CMD_W  = 2;
  localparam int HITS_W = 2;

  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_STORE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MODIFY = 2'd2;

  localparam int SET_BITS_W    = 3;
  localparam int OFFSET_BITS_W = 6;
  localparam int WAYS_W        = 4;
  localparam int RAW_IDX_W     = (1 << SET_BITS_W) - 1;

  localparam logic [SET_BITS_W-1:0]    SET_BITS_RST    = 3'd1;
  localparam logic [OFFSET_BITS_W-1:0] OFFSET_BITS_RST = 6'd5;
  localparam logic [WAYS_W-1:0]        WAYS_RST        = 4'd1;

  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] REG_SET_BITS    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_OFFSET_BITS = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_WAYS        = 2'd2;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [SET_BITS_W-1:0]    set_bits;
    logic [OFFSET_BITS_W-1:0] offset_bits;
    logic [WAYS_W-1:0]        ways_in_use;
  } cfg_t;

endpackage

[design/sacl_intf.sv]
interface sacl_req_if;
  logic                           valid;
  logic                           ready;
  logic [sacl_pkg::CMD_W-1:0]     command;
  logic [sacl_pkg::ADDR_W-1:0]    access_address;

  modport source (output valid, command, access_address, input ready);
  modport sink   (input valid, command, access_address, output ready);
endinterface

interface sacl_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [sacl_pkg::HITS_W-1:0]    hit_count;
  logic                           was_miss;
  logic                           was_eviction;

  modport source (output valid, hit_count, was_miss, was_eviction, input ready);
  modport sink   (input valid, hit_count, was_miss, was_eviction, output ready);
endinterface

[design/set_assoc_cache_lru_tracker.sv]
// A request passes through the queue, the read state and the evaluate state before
// its response is registered. The back end handles one request at a time, in a
// tag-store read-modify-write (a read, then an evaluate-and-write on the single-port row memory).
// Reset (synchronous, active low) loads the register defaults, empties the queue
// and starts a clearing pass over all MAX_SETS rows; no request is accepted until done.
module set_assoc_cache_lru_tracker #(
  parameter int MAX_SETS = sacl_pkg::DEF_MAX_SETS,
  parameter int MAX_WAYS = sacl_pkg::DEF_MAX_WAYS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  sacl_req_if.sink                       in_req,
  sacl_rsp_if.source                     out_rsp,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [sacl_pkg::PADDR_W-1:0]   cfg_paddr,
  input  logic [sacl_pkg::PDATA_W-1:0]   cfg_pwdata,
  output logic [sacl_pkg::PDATA_W-1:0]   cfg_prdata,
  output logic                           cfg_pready
);

  localparam int SET_W = $clog2(MAX_SETS);
  localparam int TAG_W = sacl_pkg::TAG_W;
  localparam int ENT_W = 1 + TAG_W + SET_W;
  localparam int RIW   = sacl_pkg::REG_IDX_W;

  sacl_pkg::cfg_t   cfg_r;
  logic             cfg_wr;
  logic [RIW-1:0]   reg_idx;

  logic             clear_busy;
  logic             push_valid, push_ready, push_modify;
  logic [SET_W-1:0] push_set;
  logic [TAG_W-1:0] push_tag;
  logic             pop_valid, pop;
  logic [ENT_W-1:0] pop_data;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_idx    = cfg_paddr[sacl_pkg::PADDR_W-1 -: RIW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.set_bits    <= sacl_pkg::SET_BITS_RST;
      cfg_r.offset_bits <= sacl_pkg::OFFSET_BITS_RST;
      cfg_r.ways_in_use <= sacl_pkg::WAYS_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        sacl_pkg::REG_SET_BITS: begin
          cfg_r.set_bits <= cfg_pwdata[sacl_pkg::SET_BITS_W-1:0];
        end
        sacl_pkg::REG_OFFSET_BITS: begin
          cfg_r.offset_bits <= cfg_pwdata[sacl_pkg::OFFSET_BITS_W-1:0];
        end
        sacl_pkg::REG_WAYS: begin
          cfg_r.ways_in_use <= cfg_pwdata[sacl_pkg::WAYS_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      sacl_pkg::REG_SET_BITS:    cfg_prdata = sacl_pkg::PDATA_W'(cfg_r.set_bits);
      sacl_pkg::REG_OFFSET_BITS: cfg_prdata = sacl_pkg::PDATA_W'(cfg_r.offset_bits);
      sacl_pkg::REG_WAYS:        cfg_prdata = sacl_pkg::PDATA_W'(cfg_r.ways_in_use);
      default:                   cfg_prdata = '0;
    endcase
  end

  sacl_front #(
    .MAX_SETS (MAX_SETS)
  ) u_front (
    .in_req      (in_req),
    .cfg         (cfg_r),
    .clear_busy  (clear_busy),
    .push_ready  (push_ready),
    .push_valid  (push_valid),
    .push_set    (push_set),
    .push_tag    (push_tag),
    .push_modify (push_modify)
  );

  sacl_queue #(
    .WIDTH (ENT_W),
    .DEPTH (sacl_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  ({push_modify, push_tag, push_set}),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_data   (pop_data)
  );

  sacl_back #(
    .MAX_SETS (MAX_SETS),
    .MAX_WAYS (MAX_WAYS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (pop_valid),
    .q_set      (pop_data[SET_W-1:0]),
    .q_tag      (pop_data[SET_W +: TAG_W]),
    .q_modify   (pop_data[ENT_W-1]),
    .q_pop      (pop),
    .clear_busy (clear_busy),
    .out_rsp    (out_rsp)
  );

endmodule

[design/sacl_front.sv]
module sacl_front #(
  parameter int MAX_SETS = sacl_pkg::DEF_MAX_SETS
) (
  sacl_req_if.sink                        in_req,
  input  sacl_pkg::cfg_t                  cfg,
  input  logic                            clear_busy,
  input  logic                            push_ready,
  output logic                            push_valid,
  output logic [$clog2(MAX_SETS)-1:0]     push_set,
  output logic [sacl_pkg::TAG_W-1:0]      push_tag,
  output logic                            push_modify
);

  localparam int SET_W = $clog2(MAX_SETS);
  localparam int RIW   = sacl_pkg::RAW_IDX_W;

  logic [RIW-1:0] idx_raw;
  logic [RIW:0]   idx_mask;
  logic [RIW-1:0] idx_rem;
  logic [RIW-1:0] shift_total;

  assign in_req.ready = push_ready && !clear_busy;
  assign push_valid   = in_req.valid && !clear_busy;
  assign push_modify  = (in_req.command == sacl_pkg::CMD_MODIFY);

  assign idx_raw     = RIW'(in_req.access_address >> cfg.offset_bits);
  assign idx_mask    = ((RIW+1)'(1) << cfg.set_bits) - (RIW+1)'(1);
  assign shift_total = RIW'(cfg.set_bits) + RIW'(cfg.offset_bits);

  // set index folded onto the physical sets by restoring reduction
  always_comb begin
    idx_rem = idx_raw & idx_mask[RIW-1:0];
    for (int k = RIW - 1; k >= 0; k--) begin
      if (int'(idx_rem) >= (MAX_SETS << k)) begin
        idx_rem = idx_rem - RIW'(MAX_SETS << k);
      end
    end
  end

  assign push_set = SET_W'(idx_rem);
  assign push_tag = (int'(shift_total) >= sacl_pkg::ADDR_W) ? '0 :
                    sacl_pkg::TAG_W'(in_req.access_address >> shift_total);

endmodule

[design/sacl_queue.sv]
module sacl_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = sacl_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = entries_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[design/sacl_back.sv]
`include "set_assoc_cache_lru_tracker_defines.svh"

module sacl_back #(
  parameter int MAX_SETS = sacl_pkg::DEF_MAX_SETS,
  parameter int MAX_WAYS = sacl_pkg::DEF_MAX_WAYS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  sacl_pkg::cfg_t                  cfg,
  input  logic                            q_valid,
  input  logic [$clog2(MAX_SETS)-1:0]     q_set,
  input  logic [sacl_pkg::TAG_W-1:0]      q_tag,
  input  logic                            q_modify,
  output logic                            q_pop,
  output logic                            clear_busy,
  sacl_rsp_if.source                      out_rsp
);

  localparam int SET_W   = $clog2(MAX_SETS);
  localparam int TAG_W   = sacl_pkg::TAG_W;
  localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int AGE_W   = WAY_W;
  localparam int WCNT_W  = $clog2(MAX_WAYS + 1);
  localparam int ENTRY_W = 1 + TAG_W + AGE_W;
  localparam int ROW_W   = MAX_WAYS * ENTRY_W;
  localparam int HITS_W  = sacl_pkg::HITS_W;
  localparam logic [AGE_W-1:0] AGE_CAP = AGE_W'(MAX_WAYS - 1);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_READ  = 3'b010,
    ST_EVAL  = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  logic [SET_W-1:0]   clr_idx_r, clr_idx_nxt;
  logic [SET_W-1:0]   cur_set_r;
  logic [TAG_W-1:0]   cur_tag_r;
  logic               cur_mod_r;
  logic [ROW_W-1:0]   rd_row_r;
  logic [ROW_W-1:0]   mem [MAX_SETS];

  logic               out_valid_r;
  logic [HITS_W-1:0]  out_hits_r;
  logic               out_miss_r;
  logic               out_evict_r;

  logic               res_load;
  logic               mem_we;
  logic [SET_W-1:0]   mem_waddr;
  logic [ROW_W-1:0]   mem_wdata;

  logic [WCNT_W-1:0]  n_used;
  logic [MAX_WAYS-1:0] use_way;
  logic [MAX_WAYS-1:0] row_valid;
  logic [TAG_W-1:0]   row_tag [MAX_WAYS];
  logic [AGE_W-1:0]   row_age [MAX_WAYS];

  logic               hit_found, empty_found;
  logic [WAY_W-1:0]   hit_way, empty_way, lru_way, victim;
  logic [AGE_W-1:0]   lru_age, old_age;
  logic               vic_valid, evicted;
  logic [MAX_WAYS-1:0] victim_oh;
  logic [ROW_W-1:0]   new_row;

  always_comb begin
    if (cfg.ways_in_use == '0) begin
      n_used = WCNT_W'(1);
    end else if (int'(cfg.ways_in_use) > MAX_WAYS) begin
      n_used = WCNT_W'(MAX_WAYS);
    end else begin
      n_used = WCNT_W'(cfg.ways_in_use);
    end
  end

  // entry layout: {valid, tag, age}
  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      use_way[w]   = (WCNT_W'(w) < n_used);
      row_valid[w] = rd_row_r[w*ENTRY_W + ENTRY_W - 1];
      row_tag[w]   = rd_row_r[w*ENTRY_W + AGE_W +: TAG_W];
      row_age[w]   = rd_row_r[w*ENTRY_W +: AGE_W];
    end
  end

  always_comb begin
    hit_found   = 1'b0;
    hit_way     = '0;
    empty_found = 1'b0;
    empty_way   = '0;
    lru_way     = '0;
    lru_age     = row_age[0];
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (use_way[w]) begin
        if (!hit_found && row_valid[w] && (row_tag[w] == cur_tag_r)) begin
          hit_found = 1'b1;
          hit_way   = WAY_W'(w);
        end
        if (!empty_found && !row_valid[w]) begin
          empty_found = 1'b1;
          empty_way   = WAY_W'(w);
        end
        if ((w != 0) && (row_age[w] > lru_age)) begin
          lru_age = row_age[w];
          lru_way = WAY_W'(w);
        end
      end
    end
  end

  assign victim    = hit_found ? hit_way : (empty_found ? empty_way : lru_way);
  assign evicted   = !hit_found && !empty_found;
  assign vic_valid = row_valid[victim];
  assign old_age   = row_age[victim];

  // recency update: touched line goes to age 0
  always_comb begin
    logic             nv;
    logic [TAG_W-1:0] nt;
    logic [AGE_W-1:0] na;
    new_row   = rd_row_r;
    victim_oh = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      nv = row_valid[w];
      nt = row_tag[w];
      na = row_age[w];
      if (WAY_W'(w) == victim) begin
        victim_oh[w] = 1'b1;
        nv = 1'b1;
        na = '0;
        if (!hit_found) begin
          nt = cur_tag_r;
        end
      end else if (use_way[w] && row_valid[w]) begin
        if (vic_valid) begin
          if (row_age[w] < old_age) begin
            na = row_age[w] + AGE_W'(1);
          end
        end else if (row_age[w] < AGE_CAP) begin
          na = row_age[w] + AGE_W'(1);
        end
      end
      new_row[w*ENTRY_W +: ENTRY_W] = {nv, nt, na};
    end
  end

  assign res_load   = (state_r == ST_EVAL) && (!out_valid_r || out_rsp.ready);
  assign q_pop      = (state_r == ST_READ) && q_valid;
  assign clear_busy = (state_r == ST_CLEAR);

  assign mem_we    = (state_r == ST_CLEAR) || res_load;
  assign mem_waddr = (state_r == ST_CLEAR) ? clr_idx_r : cur_set_r;
  assign mem_wdata = (state_r == ST_CLEAR) ? '0 : new_row;

  always_comb begin
    state_nxt   = state_r;
    clr_idx_nxt = clr_idx_r;
    case (state_r)
      ST_CLEAR: begin
        clr_idx_nxt = clr_idx_r + SET_W'(1);
        if (clr_idx_r == SET_W'(MAX_SETS - 1)) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        if (q_valid) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (res_load) begin
          state_nxt = ST_READ;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_idx_r <= clr_idx_nxt;
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_set_r <= q_set;
      cur_tag_r <= q_tag;
      cur_mod_r <= q_modify;
    end
    if (res_load) begin
      out_hits_r  <= HITS_W'(hit_found) + HITS_W'(cur_mod_r);
      out_miss_r  <= !hit_found;
      out_evict_r <= evicted;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (q_pop) begin
      rd_row_r <= mem[q_set];
    end
  end

  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.hit_count    = out_hits_r;
  assign out_rsp.was_miss     = out_miss_r;
  assign out_rsp.was_eviction = out_evict_r;

  `SACL_ASSERT_IMP(a_no_rsp_in_clear, state_r == ST_CLEAR, !out_valid_r,
    "response valid during clearing pass")
  `SACL_ASSERT_IMP(a_hit_no_evict, out_valid_r && !out_miss_r, !out_evict_r,
    "hit reported with eviction")
  `SACL_ASSERT_IMP(a_miss_hits, out_valid_r && out_miss_r,
    out_hits_r == HITS_W'(0) || out_hits_r == HITS_W'(1), "miss with two hits")
  `SACL_ASSERT_IMP(a_victim_used, state_r == ST_EVAL, $onehot(victim_oh & use_way),
    "victim way not in use")
  `SACL_ASSERT_NEXT(a_commit_to_read, res_load, state_r == ST_READ,
    "request commit did not return to read")

endmodule
